// ----- rtl/atan2_pkg.sv -----
// Package for the atan2 polynomial approximation pipeline.
// Holds flag struct, Q1.16 coefficients and fixed sizes; no dependencies.
`default_nettype none
package atan2_pkg;

  // Quotient bits of the ratio lo/hi in unsigned Q1.16 (value up to 1.0)
  localparam int unsigned QBITS = 17;
  // Fraction bits of the polynomial arithmetic
  localparam int unsigned QFRAC = 16;
  // Signed accumulator width of the Horner steps
  localparam int unsigned ACCW = 18;

  // Horner coefficients, highest order first: C9, C7, C5, C3, C1
  localparam logic signed [ACCW-1:0] COEF [0:4] = '{
    18'sd1365, -18'sd5579, 18'sd11806, -18'sd21647, 18'sd65527
  };

  localparam logic signed [19:0] HALFPI_Q16 = 20'sd102944;
  localparam logic [63:0] PI_Q32     = 64'd13493037705;
  localparam logic [63:0] HALFPI_Q32 = 64'd6746518852;

  // Per-word side information carried along the pipeline
  typedef struct packed {
    logic ysign;
    logic yzero;
    logic xneg;
    logic xzero;
    logic swap;
  } flags_t;

endpackage
`default_nettype wire

// ----- rtl/atan2_polynomial_approx.sv -----
// Top level of the atan2 polynomial approximation: one fully pipelined datapath.
// Depends on atan2_pkg for flags, coefficients and constants.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------
//  input    | vector_valid, vector_ready | vector_y, vector_x
//  output   | angle_valid, angle_ready   | angle
//
// One word per cycle is taken while the output is not stalled. The pipeline is one input register,
// 17 restoring-divide stages (one quotient bit each), one squaring stage,
// four Horner multiply stages, one final multiply, one conversion stage and
// the output register. Reset clears all stage valid bits. A stalled output
// holds the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module atan2_polynomial_approx #(
  parameter int unsigned IN_BITS         = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 13
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         vector_valid,
  output logic                              vector_ready,
  input  wire logic signed [IN_BITS-1:0]    vector_y,
  input  wire logic signed [IN_BITS-1:0]    vector_x,
  output logic                              angle_valid,
  input  wire logic                         angle_ready,
  output logic signed [ANGLE_FRAC_BITS+2:0] angle
);

  localparam int unsigned N   = IN_BITS;
  localparam int unsigned OW  = ANGLE_FRAC_BITS + 3;
  localparam int unsigned AW  = OW + 2;
  localparam int unsigned QB  = atan2_pkg::QBITS;
  localparam int unsigned AC  = atan2_pkg::ACCW;
  localparam int unsigned SO  = 32 - ANGLE_FRAC_BITS;
  localparam logic [63:0] PI_O64 =
    (atan2_pkg::PI_Q32 + (64'd1 << (SO - 1))) >> SO;
  localparam logic [63:0] HPI_O64 =
    (atan2_pkg::HALFPI_Q32 + (64'd1 << (SO - 1))) >> SO;
  localparam logic signed [AW-1:0] PI_O  = AW'(PI_O64);
  localparam logic signed [AW-1:0] HPI_O = AW'(HPI_O64);
  localparam int unsigned SHR = (ANGLE_FRAC_BITS < 16) ? 16 - ANGLE_FRAC_BITS : 0;
  localparam int unsigned SHL = (ANGLE_FRAC_BITS > 16) ? ANGLE_FRAC_BITS - 16 : 0;
  localparam logic [63:0] RND = (ANGLE_FRAC_BITS < 16) ? (64'd1 << (SHR - 1)) : 64'd0;

  // Global advance: pipeline moves unless the output word is held
  logic adv;
  assign adv          = !angle_valid || angle_ready;
  assign vector_ready = adv;

  // ---------------- input register: magnitudes, swap, flags
  logic [N-1:0] ay, ax;
  assign ay = vector_y[N-1] ? N'(~vector_y + 1'b1) : N'(vector_y);
  assign ax = vector_x[N-1] ? N'(~vector_x + 1'b1) : N'(vector_x);

  logic                    dv   [0:QB];
  logic [N:0]              drem [0:QB];
  logic [N-1:0]            dhi  [0:QB];
  logic [QB-1:0]           dq   [0:QB];
  atan2_pkg::flags_t       dfl  [0:QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= vector_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dfl[0].ysign <= vector_y[N-1];
      dfl[0].yzero <= (vector_y == '0);
      dfl[0].xneg  <= vector_x[N-1];
      dfl[0].xzero <= (vector_x == '0);
      dfl[0].swap  <= (ay > ax);
      drem[0]      <= {1'b0, (ay > ax) ? ax : ay};
      dhi[0]       <= (ay > ax) ? ay : ax;
      dq[0]        <= '0;
    end
  end

  // ---------------- restoring divide, one quotient bit per stage
  for (genvar k = 1; k <= QB; k++) begin : g_div
    logic [N:0] trial;
    logic       ge;
    assign trial = (k == 1) ? drem[k-1] : {drem[k-1][N-1:0], 1'b0};
    assign ge    = (trial >= {1'b0, dhi[k-1]});

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (adv) begin
        dv[k] <= dv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        drem[k]       <= ge ? trial - {1'b0, dhi[k-1]} : trial;
        dhi[k]        <= dhi[k-1];
        dfl[k]        <= dfl[k-1];
        dq[k]         <= dq[k-1] | (QB'(ge) << (QB - k));
      end
    end
  end

  // ---------------- square of the ratio, Horner seed
  logic [2*QB-1:0] rsq;
  assign rsq = dq[QB] * dq[QB];

  logic                  hv  [0:4];
  logic [QB-1:0]         hr  [0:4];
  logic [QB-1:0]         hr2 [0:4];
  logic signed [AC-1:0]  hacc[0:4];
  atan2_pkg::flags_t     hfl [0:4];

  always_ff @(posedge clk) begin
    if (rst) begin
      hv[0] <= 1'b0;
    end else if (adv) begin
      hv[0] <= dv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hr[0]   <= dq[QB];
      hr2[0]  <= rsq[QB+15:16];
      hacc[0] <= atan2_pkg::COEF[0];
      hfl[0]  <= dfl[QB];
    end
  end

  // ---------------- Horner steps: acc = c + floor(r2*acc / 2^16)
  for (genvar k = 1; k <= 4; k++) begin : g_horner
    logic signed [QB+AC-1:0] prod;
    assign prod = $signed({1'b0, hr2[k-1]}) * hacc[k-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        hv[k] <= 1'b0;
      end else if (adv) begin
        hv[k] <= hv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        hacc[k] <= atan2_pkg::COEF[k] + AC'(prod >>> 16);
        hr[k]   <= hr[k-1];
        hr2[k]  <= hr2[k-1];
        hfl[k]  <= hfl[k-1];
      end
    end
  end

  // ---------------- odd term p = floor(r*acc / 2^16), pi/2 reflection, negative result clamped to zero
  logic signed [QB+AC:0] podd;
  assign podd = $signed({1'b0, hr[4]}) * hacc[4];

  logic signed [19:0] pq, pref;
  assign pq   = 20'(podd >>> 16);
  assign pref = hfl[4].swap ? atan2_pkg::HALFPI_Q16 - pq : pq;

  logic               pv;
  logic [19:0]        pval;
  atan2_pkg::flags_t  pfl;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (adv) begin
      pv <= hv[4];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pval <= pref[19] ? '0 : pref;
      pfl  <= hfl[4];
    end
  end

  // ---------------- convert to output format and apply the sign
  logic [63:0]         pconv;
  logic signed [AW-1:0] amag, asgn;
  assign pconv = ((64'(pval) + RND) >> SHR) << SHL;
  assign amag  = AW'(pconv);
  assign asgn  = (pfl.ysign != pfl.xneg) ? -amag : amag;

  logic                 cv;
  logic signed [AW-1:0] cval;
  atan2_pkg::flags_t    cfl;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= 1'b0;
    end else if (adv) begin
      cv <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cval <= asgn;
      cfl  <= pfl;
    end
  end

  // ---------------- quadrant fix, axis cases, clamp into output register
  logic signed [AW-1:0] aq, afin;
  always_comb begin
    aq = cval;
    if (cfl.xneg) begin
      aq = cfl.ysign ? cval - PI_O : cval + PI_O;
    end
    if (cfl.xzero) begin
      aq = cfl.yzero ? '0 : (cfl.ysign ? -HPI_O : HPI_O);
    end
    afin = aq;
    if (aq > PI_O) begin
      afin = PI_O;
    end else if (aq < -PI_O) begin
      afin = -PI_O;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_valid <= 1'b0;
    end else if (adv) begin
      angle_valid <= cv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      angle <= OW'(afin);
    end
  end

  // ---------------- assertions
  a_range: assert property (@(posedge clk) disable iff (rst)
    angle_valid |-> ($signed(angle) <= OW'(PI_O) && $signed(angle) >= -OW'(PI_O)))
    else $error("angle out of range");

  a_ready: assert property (@(posedge clk)
    vector_ready == (!angle_valid || angle_ready))
    else $error("input ready does not follow output stall");

  a_reset: assert property (@(posedge clk)
    rst |=> !angle_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (dv[QB] && !adv) |=> (dv[QB] && $stable(dq[QB])))
    else $error("divider output changed during stall");

endmodule
`default_nettype wire
